@@ src/rphj_pkg.sv @@
// Shared constants and types for the radix hash join probe block.
package rphj_pkg;

   localparam int BUILD_DEPTH  = 4096;
   localparam int BUCKET_DEPTH = 1024;
   localparam int MAX_RUN      = 64;

   localparam int BUILD_AW  = $clog2(BUILD_DEPTH);
   localparam int BUILD_CW  = $clog2(BUILD_DEPTH + 1);
   localparam int BUCKET_AW = $clog2(BUCKET_DEPTH);
   localparam int START_W   = 13;
   localparam int POS_W     = (BUILD_CW > START_W) ? BUILD_CW : START_W;
   localparam int WORD_W    = 32;

   typedef enum logic [1:0] {
      ACT_LOAD_BUILD = 2'd0,
      ACT_LOAD_START = 2'd1,
      ACT_PROBE      = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_TRUNC = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_LOW_BITS     = 2'd0,
      CSR_HIGH_BITS    = 2'd1,
      CSR_BUILD_COUNT  = 2'd2,
      CSR_BUCKET_COUNT = 2'd3
   } csr_type;

   typedef struct packed {
      logic                en;
      logic [BUILD_AW-1:0] addr;
      logic [WORD_W-1:0]   hash;
      logic [WORD_W-1:0]   position;
   } build_wr_type;

   typedef struct packed {
      logic                start;
      logic [BUILD_CW-1:0] first;
      logic [BUILD_CW-1:0] stop;
      logic [WORD_W-1:0]   hash;
      logic [WORD_W-1:0]   position;
      status_type          status;
   } scan_cmd_type;

endpackage

@@ src/rphj_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rphj_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

@@ src/rphj_scan.sv @@
// Bucket scan engine: build store, hash compare, pending pair and result register.
module rphj_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  rphj_pkg::build_wr_type build_wr,
   input  rphj_pkg::scan_cmd_type cmd,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_left_position,
   output logic [31:0]           rsp_right_position,
   output logic                  rsp_matched,
   output logic                  rsp_last,
   output logic [1:0]            rsp_status
);
   import rphj_pkg::*;

   typedef enum logic [1:0] {SC_IDLE, SC_RUN, SC_FINAL} sc_state_type;

   sc_state_type        state_ff, state_in;
   logic [BUILD_CW-1:0] ptr_ff, ptr_in;
   logic [BUILD_CW-1:0] stop_ff, stop_in;
   logic [WORD_W-1:0]   hash_ff, hash_in;
   logic [WORD_W-1:0]   pos_ff, pos_in;
   status_type          status_ff, status_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [WORD_W-1:0]   pend_pos_ff, pend_pos_in;

   logic                out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]   out_left_ff, out_left_in;
   logic [WORD_W-1:0]   out_right_ff, out_right_in;
   logic                out_matched_ff, out_matched_in;
   logic                out_last_ff, out_last_in;
   status_type          out_status_ff, out_status_in;

   logic [2*WORD_W-1:0] rd_data;
   logic                rd_en;
   logic                rd_more;
   logic                match;
   logic                push;
   logic                out_free;
   logic                stall;

   rphj_ram #(
      .WIDTH(2 * WORD_W),
      .DEPTH(BUILD_DEPTH)
   ) u_build_ram (
      .clock  (clock),
      .wr_en  (build_wr.en),
      .wr_addr(build_wr.addr),
      .wr_data({build_wr.hash, build_wr.position}),
      .rd_en  (rd_en),
      .rd_addr(ptr_ff[BUILD_AW-1:0]),
      .rd_data(rd_data)
   );

   assign rd_more  = ptr_ff < stop_ff;
   assign match    = cmp_valid_ff && (rd_data[2*WORD_W-1:WORD_W] == hash_ff);
   // a new match flushes the previous one, which is then known not to be last
   assign push     = match && pend_valid_ff;
   assign out_free = !out_valid_ff || rsp_ready;
   assign stall    = push && !out_free;
   assign rd_en    = (state_ff == SC_RUN) && !stall && rd_more;

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      stop_in        = stop_ff;
      hash_in        = hash_ff;
      pos_in         = pos_ff;
      status_in      = status_ff;
      cmp_valid_in   = cmp_valid_ff;
      pend_valid_in  = pend_valid_ff;
      pend_pos_in    = pend_pos_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_left_in    = out_left_ff;
      out_right_in   = out_right_ff;
      out_matched_in = out_matched_ff;
      out_last_in    = out_last_ff;
      out_status_in  = out_status_ff;

      unique case (state_ff)
         SC_IDLE: begin
            if (cmd.start) begin
               ptr_in        = cmd.first;
               stop_in       = cmd.stop;
               hash_in       = cmd.hash;
               pos_in        = cmd.position;
               status_in     = cmd.status;
               cmp_valid_in  = 1'b0;
               pend_valid_in = 1'b0;
               state_in      = SC_RUN;
            end
         end
         SC_RUN: begin
            if (!stall) begin
               ptr_in       = ptr_ff + BUILD_CW'(rd_more);
               cmp_valid_in = rd_more;
               if (match) begin
                  pend_valid_in = 1'b1;
                  pend_pos_in   = rd_data[WORD_W-1:0];
               end
               if (push) begin
                  out_valid_in   = 1'b1;
                  out_left_in    = pos_ff;
                  out_right_in   = pend_pos_ff;
                  out_matched_in = 1'b1;
                  out_last_in    = 1'b0;
                  out_status_in  = status_ff;
               end
               if (!rd_more && !cmp_valid_ff) begin
                  state_in = SC_FINAL;
               end
            end
         end
         SC_FINAL: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_left_in    = pos_ff;
               out_right_in   = pend_valid_ff ? pend_pos_ff : '0;
               out_matched_in = pend_valid_ff;
               out_last_in    = 1'b1;
               out_status_in  = status_ff;
               state_in       = SC_IDLE;
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SC_IDLE;
         out_valid_ff  <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      ptr_ff         <= ptr_in;
      stop_ff        <= stop_in;
      hash_ff        <= hash_in;
      pos_ff         <= pos_in;
      status_ff      <= status_in;
      pend_pos_ff    <= pend_pos_in;
      out_left_ff    <= out_left_in;
      out_right_ff   <= out_right_in;
      out_matched_ff <= out_matched_in;
      out_last_ff    <= out_last_in;
      out_status_ff  <= out_status_in;
   end

   assign busy               = state_ff != SC_IDLE;
   assign rsp_valid          = out_valid_ff;
   assign rsp_left_position  = out_left_ff;
   assign rsp_right_position = out_right_ff;
   assign rsp_matched        = out_matched_ff;
   assign rsp_last           = out_last_ff;
   assign rsp_status         = out_status_ff;
endmodule

@@ src/radix_partition_hash_join_probe.sv @@
// Top level of the radix hash join probe: registers, loads, bucket lookup.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  req      | req_valid/req_ready   | action, index, hash, position
//  rsp      | rsp_valid/rsp_ready   | left_position, right_position, matched, last,
//           |                       | status
//  csr      | csr_valid/csr_ready   | csr_index, csr_data (always ready)
//
// A probe first looks up its bucket in the start table, in the states T_BUCKET, T_FIRST
// and T_LAST (two reads of the start table through its single port), then scans
// the bucket's build entries, one per cycle unless the scan stalls, and closes the scan.
// The scan stalls only when a pair must leave while the result register is full
// and not taken. Reset is synchronous; it clears control state and the registers
// but sets the bucket count to one. Stores hold nothing defined until loaded.
module radix_partition_hash_join_probe (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_index,
   input  logic [31:0] req_hash,
   input  logic [31:0] req_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_left_position,
   output logic [31:0] rsp_right_position,
   output logic        rsp_matched,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);
   import rphj_pkg::*;

   typedef enum logic [2:0] {T_IDLE, T_BUCKET, T_FIRST, T_LAST, T_WAIT} top_state_type;

   top_state_type        state_ff, state_in;
   logic [3:0]           low_bits_ff, high_bits_ff;
   logic [12:0]          build_count_ff;
   logic [10:0]          bucket_count_ff;
   logic [WORD_W-1:0]    bucket_ff, bucket_in;
   logic [WORD_W-1:0]    hash_ff, hash_in;
   logic [WORD_W-1:0]    pos_ff, pos_in;
   logic [START_W-1:0]   begin_ff, begin_in;
   logic                 has_next_ff, has_next_in;

   logic                 accept;
   action_type           action;
   logic [WORD_W-1:0]    low_mask, high_mask, bucket_calc;
   logic [WORD_W-1:0]    nb;
   logic [BUCKET_AW-1:0] start_rd_addr;
   logic [START_W-1:0]   start_rd_data;
   logic                 start_wr_en;
   logic [POS_W-1:0]     nbuild, end_raw, end_c, beg_c, run_len;
   logic [POS_W-1:0]     stop_c;
   status_type           range_status;
   build_wr_type         build_wr;
   scan_cmd_type         cmd;
   logic                 scan_busy;

   assign accept    = req_valid && req_ready;
   assign req_ready = state_ff == T_IDLE;
   assign csr_ready = 1'b1;
   assign action    = action_type'(req_action);

   // swap the two radix fields of the hash
   assign low_mask    = (WORD_W'(1) << low_bits_ff) - WORD_W'(1);
   assign high_mask   = ((WORD_W'(1) << high_bits_ff) - WORD_W'(1)) << low_bits_ff;
   assign bucket_calc = ((req_hash & low_mask) << high_bits_ff)
                      | ((req_hash & high_mask) >> low_bits_ff);

   assign nb = (WORD_W'(bucket_count_ff) > WORD_W'(BUCKET_DEPTH))
             ? WORD_W'(BUCKET_DEPTH) : WORD_W'(bucket_count_ff);

   assign build_wr.en       = accept && (action == ACT_LOAD_BUILD)
                            && (WORD_W'(req_index) < WORD_W'(BUILD_DEPTH));
   assign build_wr.addr     = BUILD_AW'(req_index);
   assign build_wr.hash     = req_hash;
   assign build_wr.position = req_position;

   assign start_wr_en = accept && (action == ACT_LOAD_START)
                      && (WORD_W'(req_index) < WORD_W'(BUCKET_DEPTH));

   assign start_rd_addr = (state_ff == T_FIRST) ? BUCKET_AW'(bucket_ff + WORD_W'(1))
                                                : BUCKET_AW'(bucket_ff);

   rphj_ram #(
      .WIDTH(START_W),
      .DEPTH(BUCKET_DEPTH)
   ) u_start_ram (
      .clock  (clock),
      .wr_en  (start_wr_en),
      .wr_addr(BUCKET_AW'(req_index)),
      .wr_data(req_position[START_W-1:0]),
      .rd_en  (1'b1),
      .rd_addr(start_rd_addr),
      .rd_data(start_rd_data)
   );

   // bucket bounds, clamped to the store and to the run cap
   always_comb begin
      nbuild = (POS_W'(build_count_ff) > POS_W'(BUILD_DEPTH))
             ? POS_W'(BUILD_DEPTH) : POS_W'(build_count_ff);
      end_raw = has_next_ff ? POS_W'(start_rd_data) : nbuild;
      end_c   = (end_raw > POS_W'(BUILD_DEPTH)) ? POS_W'(BUILD_DEPTH) : end_raw;
      beg_c   = (POS_W'(begin_ff) > end_c) ? end_c : POS_W'(begin_ff);
      run_len = end_c - beg_c;
      if (run_len > POS_W'(MAX_RUN)) begin
         stop_c       = beg_c + POS_W'(MAX_RUN);
         range_status = ST_TRUNC;
      end else begin
         stop_c       = end_c;
         range_status = ST_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      bucket_in    = bucket_ff;
      hash_in      = hash_ff;
      pos_in       = pos_ff;
      begin_in     = begin_ff;
      has_next_in  = has_next_ff;
      cmd.start    = 1'b0;
      cmd.first    = BUILD_CW'(beg_c);
      cmd.stop     = BUILD_CW'(stop_c);
      cmd.hash     = hash_ff;
      cmd.position = pos_ff;
      cmd.status   = range_status;

      unique case (state_ff)
         T_IDLE: begin
            if (accept && (action == ACT_PROBE)) begin
               bucket_in = bucket_calc;
               hash_in   = req_hash;
               pos_in    = req_position;
               state_in  = T_BUCKET;
            end
         end
         T_BUCKET: begin
            if (bucket_ff >= nb) begin
               cmd.start  = 1'b1;
               cmd.first  = '0;
               cmd.stop   = '0;
               cmd.status = ST_RANGE;
               state_in   = T_WAIT;
            end else begin
               state_in = T_FIRST;
            end
         end
         T_FIRST: begin
            begin_in    = start_rd_data;
            has_next_in = (bucket_ff + WORD_W'(1)) < nb;
            state_in    = T_LAST;
         end
         T_LAST: begin
            cmd.start = 1'b1;
            state_in  = T_WAIT;
         end
         T_WAIT: begin
            if (!scan_busy) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= T_IDLE;
         low_bits_ff     <= '0;
         high_bits_ff    <= '0;
         build_count_ff  <= '0;
         bucket_count_ff <= 11'd1;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               8'(CSR_LOW_BITS):     low_bits_ff     <= csr_data[3:0];
               8'(CSR_HIGH_BITS):    high_bits_ff    <= csr_data[3:0];
               8'(CSR_BUILD_COUNT):  build_count_ff  <= csr_data[12:0];
               8'(CSR_BUCKET_COUNT): bucket_count_ff <= csr_data[10:0];
               default: begin
               end
            endcase
         end
      end
      bucket_ff   <= bucket_in;
      hash_ff     <= hash_in;
      pos_ff      <= pos_in;
      begin_ff    <= begin_in;
      has_next_ff <= has_next_in;
   end

   rphj_scan u_scan (
      .clock             (clock),
      .reset             (reset),
      .build_wr          (build_wr),
      .cmd               (cmd),
      .busy              (scan_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_position (rsp_left_position),
      .rsp_right_position(rsp_right_position),
      .rsp_matched       (rsp_matched),
      .rsp_last          (rsp_last),
      .rsp_status        (rsp_status)
   );
endmodule

@@ bench/tb_radix_partition_hash_join_probe.sv @@
// Testbench for the radix hash join probe: mirrored stores, pair prediction and result checks.
module tb_radix_partition_hash_join_probe;
   timeunit 1ns;
   timeprecision 1ps;
   import rphj_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 120;
   localparam int TAG_POOL = 4;

   typedef struct {
      logic [31:0] left;
      logic [31:0] right;
      logic        matched;
      logic        last;
      logic [1:0]  status;
   } join_pair_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = '0;
   logic [11:0] req_index = '0;
   logic [31:0] req_hash = '0;
   logic [31:0] req_position = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_left_position;
   logic [31:0] rsp_right_position;
   logic        rsp_matched;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // mirror of the block's stores and registers
   logic [31:0] mirror_hash [BUILD_DEPTH];
   logic [31:0] mirror_pos [BUILD_DEPTH];
   logic [12:0] mirror_start [BUCKET_DEPTH];
   logic [3:0]  cfg_low = '0;
   logic [3:0]  cfg_high = '0;
   logic [12:0] cfg_build = '0;
   logic [10:0] cfg_buckets = 11'd1;

   join_pair_t pending_pairs[$];
   int bad_count = 0;
   bit idle_on = 1'b1;

   radix_partition_hash_join_probe uut (.*);

   always #1 clock = ~clock;

   always @(negedge clock) rsp_ready = !idle_on || ($urandom_range(99) >= 26);

   function automatic logic [31:0] bucket_hash(int b, int lo, int hi, logic [31:0] tag);
      logic [63:0] v;
      v = (64'(tag) << (lo + hi)) | (64'(b & ((1 << hi) - 1)) << lo)
          | 64'((b >> hi) & ((1 << lo) - 1));
      return v[31:0];
   endfunction

   // pairs one probe yields under the current registers and stores
   function automatic void join_probe(logic [31:0] key, logic [31:0] left);
      logic [63:0] h, low_mask, high_mask, bucket;
      int nb, nbuild, first, stop, hits;
      logic [1:0] st;
      join_pair_t p;
      h = 64'(key);
      low_mask = (64'd1 << cfg_low) - 64'd1;
      high_mask = ((64'd1 << cfg_high) - 64'd1) << cfg_low;
      bucket = ((h & low_mask) << cfg_high) | ((h & high_mask) >> cfg_low);
      nb = (cfg_buckets > BUCKET_DEPTH) ? BUCKET_DEPTH : int'(cfg_buckets);
      nbuild = (cfg_build > BUILD_DEPTH) ? BUILD_DEPTH : int'(cfg_build);
      p.left = left;
      p.right = '0;
      p.matched = 1'b0;
      p.last = 1'b1;
      if (bucket >= 64'(nb)) begin
         p.status = ST_RANGE;
         pending_pairs.push_back(p);
         return;
      end
      first = mirror_start[bucket];
      stop = (bucket + 1 < nb) ? int'(mirror_start[bucket + 1]) : nbuild;
      if (stop > BUILD_DEPTH) stop = BUILD_DEPTH;
      if (first > stop) first = stop;
      st = ST_OK;
      if (stop - first > MAX_RUN) begin
         stop = first + MAX_RUN;
         st = ST_TRUNC;
      end
      hits = 0;
      for (int r = first; r < stop; r++) begin
         if (mirror_hash[r] == key) begin
            p.right = mirror_pos[r];
            p.matched = 1'b1;
            p.last = 1'b0;
            p.status = st;
            pending_pairs.push_back(p);
            hits++;
         end
      end
      if (hits == 0) begin
         p.status = st;
         pending_pairs.push_back(p);
      end else begin
         pending_pairs[pending_pairs.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic void record_request(logic [1:0] act, logic [11:0] idx,
                                          logic [31:0] key, logic [31:0] pos);
      case (act)
         ACT_LOAD_BUILD: begin
            mirror_hash[idx] = key;
            mirror_pos[idx] = pos;
         end
         ACT_LOAD_START: if (idx < BUCKET_DEPTH) mirror_start[idx] = pos[12:0];
         ACT_PROBE: join_probe(key, pos);
         default: ;
      endcase
   endfunction

   task automatic send_request(logic [1:0] act, logic [11:0] idx,
                               logic [31:0] key, logic [31:0] pos);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 26) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_action = act;
      req_index = idx;
      req_hash = key;
      req_position = pos;
      do @(posedge clock); while (!req_ready);
      record_request(act, idx, key, pos);
   endtask

   // hold off new requests until every pair is back and the block has settled
   task automatic wait_for_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LOW_BITS: cfg_low = data[3:0];
         CSR_HIGH_BITS: cfg_high = data[3:0];
         CSR_BUILD_COUNT: cfg_build = data[12:0];
         CSR_BUCKET_COUNT: cfg_buckets = data[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(posedge clock) begin
      join_pair_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            if (bad_count < 10)
               $display("unexpected result: left %h right %h matched %b last %b status %0d",
                        rsp_left_position, rsp_right_position, rsp_matched, rsp_last,
                        rsp_status);
            bad_count++;
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_left_position !== want.left || rsp_right_position !== want.right ||
                rsp_matched !== want.matched || rsp_last !== want.last ||
                rsp_status !== want.status) begin
               if (bad_count < 10) begin
                  $display("mismatch expected: left %h right %h matched %b last %b status %0d",
                           want.left, want.right, want.matched, want.last, want.status);
                  $display("           actual: left %h right %h matched %b last %b status %0d",
                           rsp_left_position, rsp_right_position, rsp_matched, rsp_last,
                           rsp_status);
               end
               bad_count++;
            end
         end
      end
   end

   // every entry of both stores gets written here, so later probes never read garbage
   task automatic test_full_store();
      write_csr(CSR_LOW_BITS, 5);
      write_csr(CSR_HIGH_BITS, 5);
      write_csr(CSR_BUILD_COUNT, BUILD_DEPTH);
      write_csr(CSR_BUCKET_COUNT, BUCKET_DEPTH);
      for (int i = 0; i < BUCKET_DEPTH; i++)
         send_request(ACT_LOAD_START, 12'(i), $urandom,
                      ($urandom & 32'hFFFF_E000) | 32'(i * 4));
      for (int i = 0; i < BUILD_DEPTH; i++)
         send_request(ACT_LOAD_BUILD, 12'(i),
                      bucket_hash(i / 4, 5, 5, $urandom_range(TAG_POOL - 1)), $urandom);
   endtask

   task automatic test_directed_probes();
      send_request(ACT_PROBE, '0, mirror_hash[0], 32'h0);
      send_request(ACT_PROBE, 12'hFFF, mirror_hash[BUILD_DEPTH - 1], 32'hFFFF_FFFF);
      send_request(ACT_PROBE, '0, 32'h0, $urandom);
      send_request(ACT_PROBE, '0, 32'hFFFF_FFFF, $urandom);
      send_request(ACT_PROBE, $urandom, bucket_hash(7, 5, 5, 32'hABCDE), $urandom);
      send_request(ACT_UNUSED, $urandom, $urandom, $urandom);
      // start table is shorter than the index range: dropped
      send_request(ACT_LOAD_START, 12'hFFF, $urandom, $urandom);
      send_request(ACT_PROBE, '0, mirror_hash[1022 * 4 + 1], $urandom);
   endtask

   task automatic test_bucket_count_edges();
      wait_for_idle();
      write_csr(CSR_BUCKET_COUNT, 0);
      send_request(ACT_PROBE, '0, mirror_hash[0], $urandom);
      wait_for_idle();
      write_csr(CSR_BUCKET_COUNT, 2047);
      send_request(ACT_PROBE, '0, mirror_hash[4094], $urandom);
      send_request(ACT_PROBE, '0, mirror_hash[20], $urandom);
      wait_for_idle();
      // last valid bucket runs to the build count and gets cut at the cap
      write_csr(CSR_BUCKET_COUNT, 600);
      send_request(ACT_PROBE, '0, mirror_hash[599 * 4], $urandom);
      send_request(ACT_PROBE, '0, mirror_hash[600 * 4], $urandom);
   endtask

   task automatic test_build_count_clip();
      wait_for_idle();
      write_csr(CSR_BUCKET_COUNT, BUCKET_DEPTH);
      write_csr(CSR_BUILD_COUNT, 8191);
      send_request(ACT_PROBE, '0, mirror_hash[4093], $urandom);
      wait_for_idle();
      write_csr(CSR_BUILD_COUNT, 4094);
      send_request(ACT_PROBE, '0, mirror_hash[4095], $urandom);
      send_request(ACT_PROBE, '0, mirror_hash[4092], $urandom);
   endtask

   task automatic test_inverted_ranges();
      send_request(ACT_LOAD_START, 12'd5, $urandom, 32'hFFFF_E000 | 32'd100);
      send_request(ACT_LOAD_START, 12'd6, $urandom, 32'd50);
      send_request(ACT_PROBE, '0, mirror_hash[20], $urandom);
      send_request(ACT_LOAD_START, 12'd10, $urandom, 32'hFFFF_FFFF);
      send_request(ACT_PROBE, '0, mirror_hash[40], $urandom);
      // bucket 9 now ends past the store: clipped, then capped
      send_request(ACT_PROBE, '0, mirror_hash[36], $urandom);
   endtask

   task automatic test_long_bucket();
      logic [31:0] key;
      key = $urandom;
      wait_for_idle();
      write_csr(CSR_LOW_BITS, 0);
      write_csr(CSR_HIGH_BITS, 0);
      write_csr(CSR_BUCKET_COUNT, 1);
      write_csr(CSR_BUILD_COUNT, 70);
      for (int i = 0; i < 70; i++) send_request(ACT_LOAD_BUILD, 12'(i), key, $urandom);
      send_request(ACT_PROBE, '0, key, $urandom);
      send_request(ACT_PROBE, '0, ~key, $urandom);
      wait_for_idle();
      write_csr(CSR_BUILD_COUNT, MAX_RUN);
      send_request(ACT_PROBE, '0, key, $urandom);
      wait_for_idle();
      write_csr(CSR_BUILD_COUNT, 0);
      send_request(ACT_PROBE, '0, key, $urandom);
   endtask

   task automatic test_wide_fields();
      wait_for_idle();
      write_csr(CSR_LOW_BITS, 15);
      write_csr(CSR_HIGH_BITS, 15);
      write_csr(CSR_BUILD_COUNT, BUILD_DEPTH);
      write_csr(CSR_BUCKET_COUNT, BUCKET_DEPTH);
      send_request(ACT_LOAD_BUILD, 12'd13, (32'd3 << 15) | (32'd2 << 30), $urandom);
      send_request(ACT_PROBE, '0, (32'd3 << 15) | (32'd2 << 30), $urandom);
      send_request(ACT_PROBE, '0, $urandom, $urandom);
      wait_for_idle();
      write_csr(CSR_HIGH_BITS, 0);
      send_request(ACT_PROBE, '0, 32'hFFFF_0009, $urandom);
      wait_for_idle();
      write_csr(CSR_LOW_BITS, 0);
      write_csr(CSR_HIGH_BITS, 15);
      send_request(ACT_PROBE, '0, 32'h8000_000D, $urandom);
   endtask

   task automatic test_csr_index();
      wait_for_idle();
      write_csr(8'd4, $urandom);
      write_csr(8'hFF, $urandom);
      write_csr(CSR_LOW_BITS, 32'hABCD_EF05);
      write_csr(CSR_HIGH_BITS, 32'h1234_5675);
      send_request(ACT_PROBE, '0, mirror_hash[100], $urandom);
   endtask

   // one layout of mostly short buckets per register setting, probed mostly with stored keys
   task automatic run_partition_phase(int lo, int hi, int nbk, int probes);
      int seg_first[];
      int seg_len[];
      logic [31:0] keys[$];
      int base, total, cap, longb, b, pick;
      logic [31:0] key;
      seg_first = new[nbk];
      seg_len = new[nbk];
      cap = 3000 / nbk;
      if (cap > 12) cap = 12;
      base = $urandom_range(256);
      total = 0;
      longb = ($urandom_range(1) == 1) ? int'($urandom_range(nbk - 1)) : -1;
      for (int i = 0; i < nbk; i++) begin
         seg_first[i] = base + total;
         seg_len[i] = (i == longb) ? int'($urandom_range(70, 65)) : int'($urandom_range(cap));
         total += seg_len[i];
      end
      wait_for_idle();
      write_csr(CSR_LOW_BITS, lo);
      write_csr(CSR_HIGH_BITS, hi);
      write_csr(CSR_BUILD_COUNT, base + total);
      write_csr(CSR_BUCKET_COUNT, nbk);
      for (int i = 0; i < nbk; i++)
         send_request(ACT_LOAD_START, 12'(i), $urandom,
                      ($urandom & 32'hFFFF_E000) | 32'(seg_first[i]));
      for (int i = 0; i < nbk; i++) begin
         for (int k = 0; k < seg_len[i]; k++) begin
            key = bucket_hash(i, lo, hi, $urandom_range(TAG_POOL - 1));
            keys.push_back(key);
            send_request(ACT_LOAD_BUILD, 12'(seg_first[i] + k), key, $urandom);
         end
      end
      for (int n = 0; n < probes; ) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            send_request(ACT_UNUSED, $urandom, $urandom, $urandom);
         end else if (pick < 9) begin
            send_request(ACT_LOAD_START, 12'($urandom_range(4095, BUCKET_DEPTH)),
                         $urandom, $urandom);
         end else if (pick < 13) begin
            send_request(ACT_LOAD_BUILD, $urandom, $urandom, $urandom);
         end else begin
            if (pick < 22) begin
               key = $urandom;
            end else begin
               b = (longb >= 0 && $urandom_range(9) == 0) ? longb
                                                          : int'($urandom_range(nbk - 1));
               if (seg_len[b] != 0 && $urandom_range(99) < 65)
                  key = keys[seg_first[b] - base + $urandom_range(seg_len[b] - 1)];
               else
                  key = bucket_hash(b, lo, hi, $urandom_range(TAG_POOL));
            end
            send_request(ACT_PROBE, $urandom, key, $urandom);
            n++;
         end
      end
   endtask

   task automatic test_random_partitions();
      int lo_set[8] = '{0, 2, 3, 4, 10, 0, 10, 6};
      int hi_set[8] = '{0, 1, 3, 2, 0, 10, 10, 4};
      int nb_set[8] = '{1, 8, 64, 40, 300, 1024, 1024, 700};
      for (int c = 0; c < 8; c++) begin
         // last phase runs with both sides streaming
         idle_on = (c != 7);
         run_partition_phase(lo_set[c], hi_set[c], nb_set[c], 50);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_full_store();
      test_directed_probes();
      test_bucket_count_edges();
      test_build_count_clip();
      test_inverted_ranges();
      test_long_bucket();
      test_wide_fields();
      test_csr_index();
      test_random_partitions();
      wait_for_idle();
      if (bad_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
